// ----- design/ddf_pkg.sv -----
`timescale 1ns / 1ps

package ddf_pkg;

   // Frame hash seed and multiplier
   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam int unsigned HASH_SHIFT = 5;  // h * 33 = (h << 5) + h

   // Destination terminator
   localparam logic [7:0] DASH_CHAR = 8'h2D;

   // Transaction commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Frame sections
   localparam logic [1:0] SEC_SOURCE  = 2'd0;
   localparam logic [1:0] SEC_DEST    = 2'd1;
   localparam logic [1:0] SEC_CONTENT = 2'd2;
   localparam logic [1:0] SEC_NONE    = 2'd3;

   // Control from the top level to the hash unit
   typedef struct packed {
      logic byte_en;    // accepted byte transaction
      logic frame_end;  // accepted end transaction, reopen frame
   } hash_ctl_type;

   // One slot of the table memory
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] stamp;
   } slot_entry_type;

endpackage

// ----- design/ddf_hash.sv -----
`timescale 1ns / 1ps

module ddf_hash import ddf_pkg::*; #(
   parameter int DEST_KEEP = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  hash_ctl_type ctl,
   input  logic [1:0]   section,
   input  logic [7:0]   char_byte,
   output logic [31:0]  hash
);

   localparam logic [3:0] KEEP = 4'(DEST_KEEP);

   logic [31:0] hash_ff, hash_in;
   logic [3:0]  dest_count_ff, dest_count_in;
   logic [2:0]  closed_ff, closed_in;
   logic [31:0] folded;
   logic [3:0]  count_inc;
   logic        sec_closed;

   assign folded    = ((hash_ff << HASH_SHIFT) + hash_ff) ^ {24'd0, char_byte};
   assign count_inc = dest_count_ff + 4'd1;

   // Is the tagged section already closed (or not a section at all)
   always_comb begin
      unique case (section)
         SEC_SOURCE:  sec_closed = closed_ff[0];
         SEC_DEST:    sec_closed = closed_ff[1];
         SEC_CONTENT: sec_closed = closed_ff[2];
         default:     sec_closed = 1'b1;
      endcase
   end

   // Byte folding and section tracking
   always_comb begin
      hash_in       = hash_ff;
      dest_count_in = dest_count_ff;
      closed_in     = closed_ff;
      if (ctl.frame_end) begin
         hash_in       = HASH_SEED;
         dest_count_in = 4'd0;
         closed_in     = 3'b000;
      end else if (ctl.byte_en && !sec_closed) begin
         if (section == SEC_DEST) begin
            if (char_byte == 8'd0 || char_byte == DASH_CHAR || dest_count_ff >= KEEP) begin
               closed_in[1] = 1'b1;
            end else begin
               hash_in       = folded;
               dest_count_in = count_inc;
               if (count_inc >= KEEP) begin
                  closed_in[1] = 1'b1;
               end
            end
         end else if (char_byte == 8'd0) begin
            closed_in[section] = 1'b1;
         end else begin
            hash_in = folded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff       <= HASH_SEED;
         dest_count_ff <= 4'd0;
         closed_ff     <= 3'b000;
      end else begin
         hash_ff       <= hash_in;
         dest_count_ff <= dest_count_in;
         closed_ff     <= closed_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ----- design/ddf_slot_ram.sv -----
`timescale 1ns / 1ps

module ddf_slot_ram import ddf_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  slot_entry_type       wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output slot_entry_type       rd_data
);

   slot_entry_type slot_mem_ff [SLOTS];
   slot_entry_type rd_data_ff;

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/digipeat_duplicate_filter_core.sv -----
`timescale 1ns / 1ps

// Duplicate-frame filter. Byte transactions (command 0) are taken one per
// cycle while no table scan runs and fold into the frame hash; they produce
// no response. An end transaction (command 1) scans the slot table through
// the one read port of the slot memory, one slot per cycle, so req_stall
// stays high after it is accepted until the result is loaded, longer if the
// previous response is still held by rsp_stall. Each end transaction gives
// one response: duplicate flag, frame hash, and the slot written when the
// frame was stored. Slot valid flags are cleared by reset, so the table
// needs no clearing pass. Write csr_wr_data/csr_wr_en only while idle.
module digipeat_duplicate_filter_core import ddf_pkg::*; #(
   parameter int SLOTS     = 16,
   parameter int DEST_KEEP = 9
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [1:0]  req_section,
   input  logic [7:0]  req_char_byte,
   input  logic [31:0] req_now_ms,
   input  logic        req_store_if_new,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_duplicate,
   output logic [31:0] rsp_frame_hash,
   output logic        rsp_stored,
   output logic [3:0]  rsp_slot_index,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int EXT_W = IDX_W + 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      window_ff;
   hash_ctl_type     hctl;
   logic [31:0]      cur_hash;
   logic             req_take;

   // frame under lookup
   logic [31:0]      key_hash_ff;
   logic [31:0]      key_now_ff;
   logic             key_store_ff;

   // scan pipeline
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_done_ff, issue_done_in;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             issue_en;

   // scan results
   logic             dup_ff, dup_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic             best_valid_ff, best_valid_in;
   logic [31:0]      best_time_ff, best_time_in;

   logic [SLOTS-1:0] slot_valid_ff;
   slot_entry_type   rd_entry;
   slot_entry_type   wr_entry;
   logic             chk_slot_valid;
   logic             load_rsp;
   logic             do_store;
   logic [EXT_W-1:0] best_ext;

   // response register
   logic             rsp_valid_ff;
   logic             rsp_dup_ff;
   logic [31:0]      rsp_hash_ff;
   logic             rsp_stored_ff;
   logic [3:0]       rsp_index_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign hctl.byte_en   = req_take && (req_command == CMD_BYTE);
   assign hctl.frame_end = req_take && (req_command == CMD_END);

   ddf_hash #(.DEST_KEEP(DEST_KEEP)) u_hash (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hctl),
      .section   (req_section),
      .char_byte (req_char_byte),
      .hash      (cur_hash)
   );

   assign issue_en = (state_ff == ST_SCAN) && !issue_done_ff;
   assign do_store = !dup_ff && key_store_ff;
   assign load_rsp = (state_ff == ST_WRITE) && (!rsp_valid_ff || !rsp_stall);

   assign wr_entry.hash  = key_hash_ff;
   assign wr_entry.stamp = key_now_ff;

   ddf_slot_ram #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (load_rsp && do_store),
      .wr_addr (best_ff),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   assign chk_slot_valid = slot_valid_ff[chk_idx_ff];
   assign best_ext       = EXT_W'(best_ff);

   // Scan: match check and replacement choice, one slot per cycle
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      best_time_in  = best_time_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (hctl.frame_end) begin
               state_in      = ST_SCAN;
               addr_in       = '0;
               issue_done_in = 1'b0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               best_in       = '0;
               best_valid_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue_en) begin
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (chk_vld_ff) begin
               if (chk_slot_valid && rd_entry.hash == key_hash_ff &&
                   (key_now_ff - rd_entry.stamp) < window_ff) begin
                  dup_in = 1'b1;
               end
               if (!free_found_ff) begin
                  if (chk_idx_ff == '0) begin
                     best_valid_in = chk_slot_valid;
                     best_time_in  = rd_entry.stamp;
                  end else if (!chk_slot_valid) begin
                     free_found_in = 1'b1;
                     best_in       = chk_idx_ff;
                  end else if (best_valid_ff && rd_entry.stamp < best_time_ff) begin
                     best_in      = chk_idx_ff;
                     best_time_in = rd_entry.stamp;
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= 32'd30000;
         chk_vld_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= issue_en;
         issue_done_ff <= issue_done_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         if (load_rsp && do_store) begin
            slot_valid_ff[best_ff] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (hctl.frame_end) begin
         key_hash_ff  <= cur_hash;
         key_now_ff   <= req_now_ms;
         key_store_ff <= req_store_if_new;
      end
      addr_ff       <= addr_in;
      chk_idx_ff    <= addr_ff;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      best_ff       <= best_in;
      best_valid_ff <= best_valid_in;
      best_time_ff  <= best_time_in;
      if (load_rsp) begin
         rsp_dup_ff    <= dup_ff;
         rsp_hash_ff   <= key_hash_ff;
         rsp_stored_ff <= do_store;
         rsp_index_ff  <= do_store ? best_ext[3:0] : 4'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duplicate  = rsp_dup_ff;
   assign rsp_frame_hash = rsp_hash_ff;
   assign rsp_stored     = rsp_stored_ff;
   assign rsp_slot_index = rsp_index_ff;

endmodule

// ----- design/ddf_checker.sv -----
`timescale 1ns / 1ps

module ddf_checker import ddf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_duplicate,
   input logic [31:0] rsp_frame_hash,
   input logic        rsp_stored,
   input logic [3:0]  rsp_slot_index
);

   // A held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_hash) &&
      $stable(rsp_duplicate) && $stable(rsp_stored) && $stable(rsp_slot_index))
      else $error("response changed while stalled");

   // A duplicate is never stored
   a_dup_not_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_duplicate && rsp_stored))
      else $error("duplicate frame stored");

   // Slot index is zero unless the frame was stored
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stored |-> rsp_slot_index == 4'd0)
      else $error("slot index set without store");

   // An end transaction starts the table scan, which holds off new requests
   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_END |=> req_stall)
      else $error("request taken during table scan");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind digipeat_duplicate_filter_core ddf_checker u_ddf_checker (.*);

// ----- verif/tb_digipeat_duplicate_filter_core.sv -----
`timescale 1ns / 1ps

module tb_digipeat_duplicate_filter_core;
   import ddf_pkg::*;

   localparam int SLOTS          = 16;
   localparam int DEST_KEEP      = 9;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = SLOTS + 8;   // end-transaction scan plus margin
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int POOL           = 6;
   localparam logic [31:0] FOLD_MUL = 32'd33;

   typedef struct {
      logic        cmd;
      logic [1:0]  sec;
      logic [7:0]  ch;
      logic [31:0] now;
      logic        store;
   } req_item_type;

   typedef struct {
      logic        dup;
      logic [31:0] hash;
      logic        stored;
      logic [3:0]  slot;
   } verdict_type;

   // Frame hash and slot table predictor, plus response queue and checks
   class dedup_scoreboard;
      logic [31:0] window_ms;
      logic [31:0] hash_acc;
      int unsigned dest_count;
      logic [2:0]  closed;
      bit          slot_valid [SLOTS];
      logic [31:0] slot_hash  [SLOTS];
      logic [31:0] slot_time  [SLOTS];
      verdict_type expected_q [$];
      int unsigned failures, reported, responses, dup_seen, stored_seen;

      function new();
         window_ms = 32'd30000;
         open_frame();
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_hash[i]  = '0;
            slot_time[i]  = '0;
         end
      endfunction

      function void open_frame();
         hash_acc   = HASH_SEED;
         dest_count = 0;
         closed     = '0;
      endfunction

      function void fold(logic [7:0] ch);
         hash_acc = (hash_acc * FOLD_MUL) ^ {24'd0, ch};
      endfunction

      // Accepted request transaction: update frame state, queue a verdict on end
      function void note_request(req_item_type it);
         verdict_type v;
         logic [31:0] age;
         int unsigned where, best;
         bit          found;
         if (it.cmd == CMD_BYTE) begin
            if (it.sec == SEC_NONE || closed[it.sec]) return;
            if (it.sec == SEC_DEST) begin
               if (it.ch == 8'd0 || it.ch == DASH_CHAR || dest_count >= DEST_KEEP) begin
                  closed[SEC_DEST] = 1'b1;
               end else begin
                  fold(it.ch);
                  dest_count++;
                  if (dest_count >= DEST_KEEP) closed[SEC_DEST] = 1'b1;
               end
            end else if (it.ch == 8'd0) begin
               closed[it.sec] = 1'b1;
            end else begin
               fold(it.ch);
            end
            return;
         end
         v.dup    = 1'b0;
         v.hash   = hash_acc;
         v.stored = 1'b0;
         v.slot   = '0;
         for (int i = 0; i < SLOTS && !v.dup; i++) begin
            age = it.now - slot_time[i];
            if (slot_valid[i] && slot_hash[i] == hash_acc && age < window_ms) v.dup = 1'b1;
         end
         if (!v.dup && it.store) begin
            // first free slot above 0, else slot 0 if free, else oldest (lowest index on tie)
            best  = 0;
            where = 0;
            found = 1'b0;
            for (int i = 1; i < SLOTS && !found; i++) begin
               if (!slot_valid[i]) begin
                  where = i;
                  found = 1'b1;
               end else if (slot_valid[0] && slot_time[i] < slot_time[best]) begin
                  best = i;
               end
            end
            if (!found) where = best;
            slot_valid[where] = 1'b1;
            slot_hash[where]  = hash_acc;
            slot_time[where]  = it.now;
            v.stored = 1'b1;
            v.slot   = 4'(where);
         end
         expected_q.push_back(v);
         open_frame();
      endfunction

      // Accepted response transaction: compare with the oldest expected verdict
      function void check_result(verdict_type got);
         verdict_type want;
         responses++;
         if (expected_q.size() == 0) begin
            failures++;
            if (reported < 10) begin
               $display("[%0t] unexpected response: dup=%0b hash=%h stored=%0b slot=%0d",
                        $time, got.dup, got.hash, got.stored, got.slot);
            end
            reported++;
            return;
         end
         want = expected_q.pop_front();
         dup_seen    += want.dup;
         stored_seen += want.stored;
         if (got.dup !== want.dup || got.hash !== want.hash ||
             got.stored !== want.stored || got.slot !== want.slot) begin
            failures++;
            if (reported < 10) begin
               $display("[%0t] mismatch: exp dup=%0b hash=%h stored=%0b slot=%0d", $time,
                        want.dup, want.hash, want.stored, want.slot);
               $display("             got dup=%0b hash=%h stored=%0b slot=%0d",
                        got.dup, got.hash, got.stored, got.slot);
            end
            reported++;
         end
      endfunction

      function void check_leftovers();
         if (expected_q.size() != 0) begin
            $display("%0d expected responses never arrived", expected_q.size());
            failures += expected_q.size();
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_BYTE;
   logic [1:0]  req_section = SEC_SOURCE;
   logic [7:0]  req_char_byte = 8'd0;
   logic [31:0] req_now_ms = 32'd0;
   logic        req_store_if_new = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_duplicate;
   logic [31:0] rsp_frame_hash;
   logic        rsp_stored;
   logic [3:0]  rsp_slot_index;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;

   dedup_scoreboard board;
   req_item_type    frame_q [$];
   int unsigned     pool [POOL];
   logic [31:0]     clock_ms = 32'd1000;
   bit              no_idle = 1'b0;
   logic            hold_request = 1'b0;
   bit              hold_done = 1'b0;
   int unsigned     hold_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     items_sent = 0;
   int unsigned     settings = 1;

   digipeat_duplicate_filter_core #(
      .SLOTS     (SLOTS),
      .DEST_KEEP (DEST_KEEP)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_section      (req_section),
      .req_char_byte    (req_char_byte),
      .req_now_ms       (req_now_ms),
      .req_store_if_new (req_store_if_new),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duplicate    (rsp_duplicate),
      .rsp_frame_hash   (rsp_frame_hash),
      .rsp_stored       (rsp_stored),
      .rsp_slot_index   (rsp_slot_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, one long hold-off on request
   always @(posedge clock) begin : rsp_side
      verdict_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_duplicate, rsp_frame_hash, rsp_stored, rsp_slot_index};
         board.check_result(got);
      end
      if (hold_request && !hold_done) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 30);
      end
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int unsigned lcg_next(inout int unsigned s);
      s = s * 32'd1103515245 + 32'd12345;
      return s >> 8;
   endfunction

   // Seeded character: mostly 1..255, some terminators, dashes where allowed
   function automatic logic [7:0] pick_char(inout int unsigned s, input bit dash_ok);
      int unsigned r;
      r = lcg_next(s);
      if (r % 16 == 0) return 8'd0;
      if (dash_ok && r % 16 == 1) return DASH_CHAR;
      return 8'(1 + (r >> 4) % 255);
   endfunction

   function automatic req_item_type byte_item(logic [1:0] sec, logic [7:0] ch);
      req_item_type it;
      it.cmd   = CMD_BYTE;
      it.sec   = sec;
      it.ch    = ch;
      it.now   = $urandom;
      it.store = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_item_type end_item(logic [31:0] now, logic store);
      req_item_type it;
      it.cmd   = CMD_END;
      it.sec   = 2'($urandom_range(3));
      it.ch    = 8'($urandom_range(255));
      it.now   = now;
      it.store = store;
      return it;
   endfunction

   // Millisecond clock: repeats, short and long steps, occasional jumps
   function automatic logic [31:0] advance_clock();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15)      clock_ms = clock_ms;
      else if (r < 50) clock_ms = clock_ms + $urandom_range(50, 1);
      else if (r < 85) clock_ms = clock_ms + $urandom_range(3000, 51);
      else if (r < 95) clock_ms = clock_ms + $urandom_range(40000, 3001);
      else             clock_ms = $urandom;
      return clock_ms;
   endfunction

   // Well-formed frame from a seed, so equal seeds give equal hashes
   function automatic void build_frame(int unsigned seed);
      logic [1:0]  order [3] = '{SEC_SOURCE, SEC_DEST, SEC_CONTENT};
      int unsigned s, n;
      s = seed;
      frame_q.delete();
      foreach (order[k]) begin
         n = lcg_next(s) % ((order[k] == SEC_DEST) ? 13 : 8);
         for (int i = 0; i < n; i++) begin
            frame_q.push_back(byte_item(order[k], pick_char(s, order[k] == SEC_DEST)));
         end
         if (lcg_next(s) % 4 == 0) begin
            frame_q.push_back(byte_item(order[k], 8'd0));
            frame_q.push_back(byte_item(order[k], pick_char(s, 1'b1)));
         end
         if (lcg_next(s) % 8 == 0) frame_q.push_back(byte_item(SEC_NONE, pick_char(s, 1'b1)));
      end
   endfunction

   task automatic send_item(req_item_type it);
      if (!no_idle && $urandom_range(99) < 30) begin
         req_valid     <= 1'b0;
         req_char_byte <= 8'($urandom_range(255));
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= it.cmd;
      req_section      <= it.sec;
      req_char_byte    <= it.ch;
      req_now_ms       <= it.now;
      req_store_if_new <= it.store;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(it);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] w);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.window_ms = w;
      settings++;
   endtask

   // Mostly repeated and fresh well-formed frames, some noise
   task automatic run_frames(int unsigned budget);
      int unsigned sent, kind;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            build_frame(pool[$urandom_range(POOL - 1)]);
         end else if (kind < 90) begin
            build_frame($urandom);
         end else begin
            frame_q.delete();
            repeat ($urandom_range(10)) begin
               frame_q.push_back(byte_item(2'($urandom_range(3)), 8'($urandom_range(255))));
            end
         end
         if (kind % 7 == 0) pool[$urandom_range(POOL - 1)] = $urandom;
         frame_q.push_back(end_item(advance_clock(), $urandom_range(99) < 80));
         foreach (frame_q[i]) send_item(frame_q[i]);
         sent += frame_q.size();
      end
   endtask

   initial begin
      board = new();
      foreach (pool[i]) pool[i] = $urandom;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty frame stored, then seen again across the time wrap
      send_item(end_item(32'hFFFF_FF00, 1'b1));
      send_item(end_item(32'h0000_0050, 1'b1));
      // terminators, bytes after a closed section, the unused section tag
      send_item(byte_item(SEC_SOURCE, 8'hFF));
      send_item(byte_item(SEC_SOURCE, 8'h00));
      send_item(byte_item(SEC_SOURCE, 8'h41));
      send_item(byte_item(SEC_DEST, 8'h00));
      send_item(byte_item(SEC_DEST, 8'h42));
      send_item(byte_item(SEC_CONTENT, 8'h80));
      send_item(byte_item(SEC_NONE, 8'h7F));
      send_item(byte_item(SEC_CONTENT, 8'h00));
      send_item(byte_item(SEC_CONTENT, 8'h01));
      send_item(end_item(32'h0000_0000, 1'b0));
      // destination longer than the kept length, dash after the limit
      for (int i = 0; i < 10; i++) send_item(byte_item(SEC_DEST, 8'h41 + 8'(i)));
      send_item(byte_item(SEC_DEST, DASH_CHAR));
      send_item(end_item(32'hFFFF_FFFF, 1'b1));
      wait_drained();

      run_frames(500);
      write_window(32'd1);
      run_frames(300);
      write_window(32'hFFFF_FFFF);
      no_idle = 1'b1;
      run_frames(300);
      no_idle = 1'b0;
      write_window(32'd0);
      run_frames(200);
      write_window(32'd2500);
      hold_request <= 1'b1;
      run_frames(700);

      wait_drained();
      board.check_leftovers();
      $display("Covered %0d request and %0d response transactions (%0d duplicates, %0d stored)",
               items_sent, board.responses, board.dup_seen, board.stored_seen);
      $display("across %0d window settings, with a %0d-cycle response hold-off and full drains.",
               settings, HOLD_CYCLES);
      if (board.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", board.failures);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
